// ===== hdl/sparse_voxel_octree_engine_defines.svh =====
// ---------------------------------------------------------------------------
// Sparse voxel octree engine: assertion macros
// Shared assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef SPARSE_VOXEL_OCTREE_ENGINE_DEFINES_SVH
`define SPARSE_VOXEL_OCTREE_ENGINE_DEFINES_SVH

// same-cycle implication
`define SVO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("svo check failed");

// next-cycle implication
`define SVO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("svo check failed");

`endif

// ===== hdl/svo_pkg.sv =====
// ---------------------------------------------------------------------------
// Sparse voxel octree engine package
// Types and fixed constants shared by the engine files.
// ---------------------------------------------------------------------------
package svo_pkg;

	localparam int COORD_EXT_W = 16;   // coordinates zero-extended to this width
	localparam int BLOCK_BITS  = 15;   // block ids saturate at 2^BLOCK_BITS - 1
	localparam logic [15:0] BLOCK_LIM = 16'((32'd1 << BLOCK_BITS) - 1);

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_PRESENT = 3'd1,
		ST_FULL    = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_MIXED   = 3'd4,
		ST_SOLID   = 3'd5
	} status_t;

	typedef enum logic [0:0] {
		KIND_INSERT = 1'b0,
		KIND_QUERY  = 1'b1
	} kind_t;

	localparam logic [0:0] REG_TREE_LEVELS = 1'b0;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DESC,
		S_QRY,
		S_CHK,
		S_CHKW,
		S_SPLIT,
		S_TAKEW,
		S_FILL,
		S_LINK,
		S_LEAF,
		S_MRG_P,
		S_MRG_B,
		S_MRG_RD,
		S_MRG_CK,
		S_MRG_W0,
		S_MRG_W1,
		S_DONE
	} fsm_t;

endpackage

// ===== hdl/svo_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, registered read data.
// ---------------------------------------------------------------------------
module svo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hdl/sparse_voxel_octree_engine.sv =====
// ---------------------------------------------------------------------------
// Sparse voxel octree engine
// Insert and query on an octree held in one node-word memory.
// ---------------------------------------------------------------------------
// One word in, one word out. The octree sits in a single-port RAM of
// NODE_WORDS 32-bit words (0 empty, bit 31 set solid with id ~word, else the
// index of eight children). The engine handles one word at a time and every
// step is one RAM access, so the RAM port sets the rate. A query walks down
// the tree level by level. An insert descends, checks for free groups, splits
// each missing level, writes the leaf, then merges empty parents bottom-up.
// Only the root word has a reset value (tracked by one flag); no clearing
// pass runs after reset. The next input word is taken while a finished
// result still waits in the output register.
// ---------------------------------------------------------------------------
module sparse_voxel_octree_engine #(
	parameter int NODE_WORDS = 4096,
	parameter int MAX_LEVELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // coord_x[7:0], coord_y[15:8], coord_z[23:16],
	                                   // block_value[39:24], target_level[43:40]
	input  logic [0:0]  s_axis_tuser,  // kind[0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // found_block[14:0]
	output logic [2:0]  m_axis_tuser,  // status[2:0]
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import svo_pkg::*;

	localparam int AW = $clog2(NODE_WORDS);
	localparam int LW = $clog2(MAX_LEVELS + 1);
	localparam int VW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int CW = COORD_EXT_W;

	// config
	logic [3:0] tree_levels_q;
	logic [LW-1:0] levels;

	assign pready = 1'b1;
	assign prdata = {28'd0, tree_levels_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_levels_q <= 4'd4;
		end else if (psel && penable && pwrite && paddr == REG_TREE_LEVELS) begin
			tree_levels_q <= pwdata[3:0];
		end
	end

	always_comb begin
		if (tree_levels_q == 4'd0) begin
			levels = LW'(1);
		end else if (32'(tree_levels_q) > MAX_LEVELS) begin
			levels = LW'(MAX_LEVELS);
		end else begin
			levels = LW'(tree_levels_q);
		end
	end

	// state
	fsm_t state_q, state_d;

	logic          kind_q;
	logic [CW-1:0] x_q, y_q, z_q;
	logic [3:0]    tl_q;
	logic [31:0]   target_q;
	logic [LW-1:0] lvl_q;
	logic [AW-1:0] idx_q;
	logic [31:0]   node_q;
	logic [LW-1:0] nvis_q;
	logic [AW-1:0] visited_q [MAX_LEVELS];
	logic [AW:0]   have_q;
	logic [AW-1:0] p_q;
	logic          pv_q;
	logic [AW-1:0] b_q;
	logic [2:0]    k_q;
	logic [AW:0]   used_q;
	logic [AW-1:0] fhead_q;
	logic          fvalid_q;
	logic          root_valid_q;
	logic          rd_root_q;
	status_t       status_q;
	logic [14:0]   found_q;
	logic          out_valid_q;
	status_t       out_status_q;
	logic [14:0]   out_found_q;

	// memory
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [31:0]   mem_wdata;
	logic [31:0]   ram_q;
	logic [31:0]   rdw;

	svo_ram #(.WIDTH(32), .DEPTH(NODE_WORDS)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (ram_q)
	);

	// unwritten root reads as empty
	assign rdw = (rd_root_q && !root_valid_q) ? 32'd0 : ram_q;

	// decode
	logic          accept;
	logic [CW-1:0] in_x, in_y, in_z;
	logic [15:0]   in_bv;
	logic [15:0]   id_sat;
	logic [31:0]   in_target;
	logic          outside;
	logic [3:0]    sbit;
	logic [2:0]    oct;
	logic          rd_branch;
	logic [AW-1:0] child;
	logic          lvl_gt_tl;
	logic          out_free;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign in_x   = CW'(s_axis_tdata[7:0]);
	assign in_y   = CW'(s_axis_tdata[15:8]);
	assign in_z   = CW'(s_axis_tdata[23:16]);
	assign in_bv  = s_axis_tdata[39:24];
	assign id_sat = (in_bv > BLOCK_LIM) ? BLOCK_LIM : in_bv;
	assign in_target = in_bv[15] ? 32'd0 : ~(32'(id_sat));
	assign outside = ((in_x >> levels) != '0) || ((in_y >> levels) != '0)
		|| ((in_z >> levels) != '0);

	assign sbit  = 4'(lvl_q - LW'(1));
	assign oct   = {z_q[sbit], y_q[sbit], x_q[sbit]};
	assign rd_branch = (rdw != 32'd0) && !rdw[31];
	assign child = rdw[AW-1:0] + AW'(oct);
	assign lvl_gt_tl = 32'(lvl_q) > 32'(tl_q);
	assign out_free = !out_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_axis_tuser == KIND_INSERT) begin
						state_d = S_DESC;
					end else if (outside) begin
						state_d = S_DONE;
					end else begin
						state_d = S_QRY;
					end
				end
			end
			S_DESC: begin
				if (lvl_q == '0) begin
					state_d = S_LEAF;
				end else if (rdw == target_q) begin
					state_d = S_DONE;
				end else if (!rd_branch) begin
					state_d = S_CHK;
				end
			end
			S_QRY: begin
				if (!(lvl_gt_tl && rd_branch)) begin
					state_d = S_DONE;
				end
			end
			S_CHK: begin
				if (32'(have_q) >= 32'(lvl_q)) begin
					state_d = S_SPLIT;
				end else if (!pv_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_CHKW;
				end
			end
			S_CHKW:   state_d = S_CHK;
			S_SPLIT: begin
				if (lvl_q == '0) begin
					state_d = S_LEAF;
				end else if (fvalid_q) begin
					state_d = S_TAKEW;
				end else begin
					state_d = S_FILL;
				end
			end
			S_TAKEW:  state_d = S_FILL;
			S_FILL: begin
				if (k_q == 3'd7) begin
					state_d = S_LINK;
				end
			end
			S_LINK:   state_d = S_SPLIT;
			S_LEAF:   state_d = S_MRG_P;
			S_MRG_P: begin
				if (nvis_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_MRG_B;
				end
			end
			S_MRG_B:  state_d = S_MRG_RD;
			S_MRG_RD: state_d = S_MRG_CK;
			S_MRG_CK: begin
				if (rdw != 32'd0) begin
					state_d = S_DONE;
				end else if (k_q == 3'd7) begin
					state_d = S_MRG_W0;
				end else begin
					state_d = S_MRG_RD;
				end
			end
			S_MRG_W0: state_d = S_MRG_W1;
			S_MRG_W1: state_d = S_MRG_P;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// memory access and handshake
	always_comb begin
		mem_we        = 1'b0;
		mem_addr      = '0;
		mem_wdata     = 32'd0;
		s_axis_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
			end
			S_DESC, S_QRY: begin
				mem_addr = child;
			end
			S_CHK: begin
				mem_addr = p_q;
			end
			S_SPLIT: begin
				mem_addr = fhead_q;
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_addr  = b_q + AW'(k_q);
				mem_wdata = node_q;
			end
			S_LINK: begin
				mem_we    = 1'b1;
				mem_addr  = idx_q;
				mem_wdata = 32'(b_q);
			end
			S_LEAF: begin
				mem_we    = 1'b1;
				mem_addr  = idx_q;
				mem_wdata = target_q;
			end
			S_MRG_P: begin
				mem_addr = visited_q[VW'(nvis_q - LW'(1))];
			end
			S_MRG_RD: begin
				mem_addr = b_q + AW'(k_q);
			end
			S_MRG_W0: begin
				mem_we   = 1'b1;
				mem_addr = p_q;
			end
			S_MRG_W1: begin
				mem_we    = 1'b1;
				mem_addr  = b_q;
				mem_wdata = fvalid_q ? 32'(fhead_q) : 32'd0;
			end
			default: begin
				mem_addr = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= (AW+1)'(1);
			fhead_q      <= '0;
			fvalid_q     <= 1'b0;
			root_valid_q <= 1'b0;
			rd_root_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_root_q <= (mem_addr == '0);
			if (mem_we && mem_addr == '0) begin
				root_valid_q <= 1'b1;
			end
			if (state_q == S_SPLIT && lvl_q != '0 && !fvalid_q) begin
				used_q <= used_q + (AW+1)'(8);
			end
			if (state_q == S_TAKEW) begin
				fhead_q  <= rdw[AW-1:0];
				fvalid_q <= rdw != 32'd0;
			end
			if (state_q == S_MRG_W1) begin
				fhead_q  <= b_q;
				fvalid_q <= 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q   <= s_axis_tuser;
					x_q      <= in_x;
					y_q      <= in_y;
					z_q      <= in_z;
					tl_q     <= s_axis_tdata[43:40];
					target_q <= in_target;
					lvl_q    <= levels;
					idx_q    <= '0;
					nvis_q   <= '0;
					found_q  <= 15'd0;
					status_q <= ST_EMPTY;
				end
			end
			S_DESC: begin
				if (lvl_q == '0) begin
					status_q <= ST_STORED;
				end else if (rdw == target_q) begin
					status_q <= ST_PRESENT;
				end else if (!rd_branch) begin
					node_q <= rdw;
					have_q <= ((AW+1)'(NODE_WORDS) - used_q) >> 3;
					p_q    <= fhead_q;
					pv_q   <= fvalid_q;
				end else begin
					visited_q[nvis_q[VW-1:0]] <= idx_q;
					nvis_q <= nvis_q + LW'(1);
					idx_q  <= child;
					lvl_q  <= lvl_q - LW'(1);
				end
			end
			S_QRY: begin
				if (lvl_gt_tl && rd_branch) begin
					lvl_q <= lvl_q - LW'(1);
				end else if (rdw == 32'd0) begin
					status_q <= ST_EMPTY;
				end else if (rdw[31]) begin
					status_q <= ST_SOLID;
					found_q  <= ~rdw[14:0];
				end else begin
					status_q <= ST_MIXED;
				end
			end
			S_CHK: begin
				if (32'(have_q) < 32'(lvl_q) && !pv_q) begin
					status_q <= ST_FULL;
				end
			end
			S_CHKW: begin
				have_q <= have_q + (AW+1)'(1);
				p_q    <= rdw[AW-1:0];
				pv_q   <= rdw != 32'd0;
			end
			S_SPLIT: begin
				k_q <= 3'd0;
				b_q <= fvalid_q ? fhead_q : used_q[AW-1:0];
			end
			S_FILL: begin
				k_q <= k_q + 3'd1;
			end
			S_LINK: begin
				idx_q <= b_q + AW'(oct);
				lvl_q <= lvl_q - LW'(1);
			end
			S_LEAF: begin
				status_q <= ST_STORED;
			end
			S_MRG_P: begin
				if (nvis_q != '0) begin
					p_q    <= visited_q[VW'(nvis_q - LW'(1))];
					nvis_q <= nvis_q - LW'(1);
				end
			end
			S_MRG_B: begin
				b_q <= rdw[AW-1:0];
				k_q <= 3'd0;
			end
			S_MRG_CK: begin
				k_q <= k_q + 3'd1;
			end
			S_DONE: begin
				if (out_free) begin
					out_status_q <= status_q;
					out_found_q  <= (kind_q == KIND_QUERY) ? found_q : 15'd0;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {1'b0, out_found_q};

endmodule

// ===== hdl/svo_checker.sv =====
// ---------------------------------------------------------------------------
// Sparse voxel octree engine checker
// Port-level checks, bound to the top level.
// ---------------------------------------------------------------------------
`include "sparse_voxel_octree_engine_defines.svh"

module svo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);
	import svo_pkg::*;

	// engine is busy right after it takes a word
	`SVO_ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// only solid results carry an id
	`SVO_ASSERT_NOW(a_found_only_solid, clk, arst_n, m_axis_tvalid && m_axis_tuser != ST_SOLID, m_axis_tdata == 16'd0)
	// status code range
	`SVO_ASSERT_NOW(a_status_range, clk, arst_n, m_axis_tvalid, m_axis_tuser <= ST_SOLID)
	// stalled result holds
	`SVO_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind sparse_voxel_octree_engine svo_checker u_svo_checker (.*);

// ===== dv/sparse_voxel_octree_engine_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sparse voxel octree engine testbench
// Drives insert and query words through the stream ports under several tree
// sizes and stall patterns, predicts each result with a local octree model
// and checks every result word in order.
// ---------------------------------------------------------------------------
module sparse_voxel_octree_engine_test;
	import svo_pkg::*;

	localparam int STORE_WORDS = 4096;
	localparam int LEVEL_CAP   = 8;
	localparam logic [31:0] SOLID_MARK = 32'h8000_0000;

	typedef struct {
		kind_t              kind;
		logic [7:0]         x, y, z;
		logic signed [15:0] value;
		logic [3:0]         level;
	} voxel_op_t;

	typedef struct {
		status_t     status;
		logic [14:0] found;
	} voxel_reply_t;

	// Octree shadow: keeps its own node store and free list, predicts one
	// reply per accepted word and compares replies in order.
	class octree_scoreboard;
		logic [31:0]  nodes [STORE_WORDS];
		int unsigned  words_used;
		int unsigned  free_head;
		bit           free_valid;
		int unsigned  tree_levels;
		voxel_reply_t replies_due [$];
		int           mismatches;

		function void clear_state();
			foreach (nodes[i]) nodes[i] = '0;
			words_used  = 1;
			free_head   = 0;
			free_valid  = 0;
			tree_levels = 4;
			mismatches  = 0;
		endfunction

		function logic [31:0] rd(int unsigned i);
			return (i < STORE_WORDS) ? nodes[i] : '0;
		endfunction

		function void wr(int unsigned i, logic [31:0] v);
			if (i < STORE_WORDS)
				nodes[i] = v;
		endfunction

		function bit is_branch(logic [31:0] w);
			return w != 0 && !w[31];
		endfunction

		function int unsigned eff_levels();
			if (tree_levels < 1) return 1;
			if (tree_levels > LEVEL_CAP) return LEVEL_CAP;
			return tree_levels;
		endfunction

		function int unsigned octant(voxel_op_t op, int s);
			return op.x[s] | (op.y[s] << 1) | (op.z[s] << 2);
		endfunction

		function int unsigned take_group();
			int unsigned b;
			if (free_valid) begin
				b = free_head;
				free_head = rd(b);
				free_valid = free_head != 0;
				return b;
			end
			b = words_used;
			words_used += 8;
			return b;
		endfunction

		function bit groups_available(int unsigned need);
			int unsigned have, p;
			bit v;
			have = (STORE_WORDS - words_used) / 8;
			p = free_head;
			v = free_valid;
			while (v && have < need) begin
				have++;
				p = rd(p);
				v = p != 0;
			end
			return have >= need;
		endfunction

		function status_t insert_cell(voxel_op_t op);
			int unsigned visited [LEVEL_CAP];
			int unsigned nvis, idx, b, p;
			logic [31:0] node, target;
			int s;
			bit empty;
			nvis = 0;
			idx = 0;
			s = int'(eff_levels()) - 1;
			// any negative id clears; ids cap at the block id limit
			target = (op.value < 0) ? '0 : ~{16'd0, op.value};
			node = rd(0);
			while (s >= 0) begin
				if (node == target) return ST_PRESENT;
				if (!is_branch(node)) break;
				visited[nvis++] = idx;
				idx = node + octant(op, s);
				node = rd(idx);
				s--;
			end
			if (s >= 0 && !groups_available(s + 1)) return ST_FULL;
			while (s >= 0) begin
				b = take_group();
				for (int i = 0; i < 8; i++) wr(b + i, node);
				wr(idx, b);
				idx = b + octant(op, s);
				s--;
			end
			wr(idx, target);
			// merge empty branches bottom-up onto the free list
			while (nvis > 0) begin
				p = visited[--nvis];
				b = rd(p);
				empty = 1;
				for (int i = 0; i < 8; i++)
					if (rd(b + i) != 0) empty = 0;
				if (!empty) break;
				wr(p, '0);
				wr(b, free_valid ? free_head : 0);
				free_head = b;
				free_valid = 1;
			end
			return ST_STORED;
		endfunction

		function voxel_reply_t query_region(voxel_op_t op);
			voxel_reply_t r;
			int unsigned lv, side;
			logic [31:0] node;
			int s;
			lv = eff_levels();
			side = 1 << lv;
			s = int'(lv) - 1;
			r.found = '0;
			r.status = ST_EMPTY;
			if (op.x >= side || op.y >= side || op.z >= side) return r;
			node = rd(0);
			while (s >= int'(op.level)) begin
				if (!is_branch(node)) break;
				node = rd(node + octant(op, s));
				s--;
			end
			if (node == 0) r.status = ST_EMPTY;
			else if (node[31]) begin
				r.status = ST_SOLID;
				r.found = ~node[14:0];
			end else
				r.status = ST_MIXED;
			return r;
		endfunction

		function void note_word(voxel_op_t op);
			voxel_reply_t r;
			if (op.kind == KIND_INSERT) begin
				r.status = insert_cell(op);
				r.found = '0;
			end else
				r = query_region(op);
			replies_due.push_back(r);
		endfunction

		function void check_word(logic [2:0] status, logic [14:0] found);
			voxel_reply_t e;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: unexpected result word status=%0d found=%0d",
						$realtime, status, found);
				return;
			end
			e = replies_due.pop_front();
			if (status !== e.status || found !== e.found) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: result mismatch: expected status=%0d found=%0d, got status=%0d found=%0d",
						$realtime, e.status, e.found, status, found);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // coord_x[7:0], coord_y[15:8], coord_z[23:16],
	                             // block_value[39:24], target_level[43:40]
	logic [0:0]  s_axis_tuser;   // kind[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // found_block[14:0]
	logic [2:0]  m_axis_tuser;   // status[2:0]
	logic        psel, penable, pwrite;
	logic [0:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	octree_scoreboard octree_sb;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	sparse_voxel_octree_engine dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("sparse_voxel_octree_engine_test: done, errors");
		$finish;
	end

	// result side: random stalls, and every accepted word goes to the checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			octree_sb.check_word(m_axis_tuser, m_axis_tdata[14:0]);
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// one word on the input stream, with random gaps ahead of it
	task automatic send_op(voxel_op_t op);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, op.level, op.value, op.z, op.y, op.x};
		s_axis_tuser  <= op.kind;
		do @(posedge clk); while (!s_axis_tready);
		octree_sb.note_word(op);
	endtask

	// let every pending result drain; the engine is idle once they are in
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (octree_sb.replies_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// register write with setup and access phases; tree size changes only while idle
	task automatic write_levels(logic [3:0] lv);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= REG_TREE_LEVELS; pwdata <= {28'd0, lv};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		octree_sb.tree_levels = lv;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic voxel_op_t make_op(kind_t k, int x, int y, int z, int v, int l);
		voxel_op_t op;
		op.kind = k;
		op.x = 8'(x); op.y = 8'(y); op.z = 8'(z);
		op.value = 16'(v);
		op.level = 4'(l);
		return op;
	endfunction

	// random word: clustered coordinates so that clears meet and merge,
	// a few ids so coarse matches happen, some wild coordinates too
	function automatic voxel_op_t random_op();
		voxel_op_t op;
		int unsigned mask, lv;
		lv = octree_sb.eff_levels();
		mask = (1 << lv) - 1;
		op.kind = ($urandom_range(99) < 55) ? KIND_INSERT : KIND_QUERY;
		if ($urandom_range(3) == 0) begin
			op.x = 8'($urandom); op.y = 8'($urandom); op.z = 8'($urandom);
		end else begin
			op.x = 8'($urandom_range(3) & mask);
			op.y = 8'($urandom_range(3) & mask);
			op.z = 8'($urandom_range(3) & mask);
		end
		case ($urandom_range(5))
			0, 1: op.value = -16'sd1;
			2: op.value = 16'($urandom_range(2));
			3: op.value = 16'sd32767;
			default: op.value = 16'($urandom_range(32767));
		endcase
		op.level = 4'($urandom_range(8));
		if (op.kind == KIND_QUERY && $urandom_range(2) == 0)
			op.level = 4'd0;
		return op;
	endfunction

	initial begin
		logic [3:0] phase_levels [6];
		voxel_op_t directed [$];
		octree_sb = new();
		octree_sb.clear_state();
		phase_levels = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd2};
		send_idle_pct = 32;
		recv_stall_pct = 54;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset tree size of four levels
		directed.push_back(make_op(KIND_QUERY, 0, 0, 0, 0, 0));         // empty tree
		directed.push_back(make_op(KIND_INSERT, 0, 0, 0, -1, 0));       // clear on empty
		directed.push_back(make_op(KIND_INSERT, 0, 0, 0, 5, 0));
		directed.push_back(make_op(KIND_INSERT, 0, 0, 0, 5, 0));        // same cell again
		directed.push_back(make_op(KIND_QUERY, 0, 0, 0, 0, 0));
		directed.push_back(make_op(KIND_QUERY, 0, 0, 0, 4, 15));
		directed.push_back(make_op(KIND_QUERY, 0, 0, 0, 8, 0));         // root decides
		directed.push_back(make_op(KIND_INSERT, 255, 255, 255, 32767, 15)); // wraps
		directed.push_back(make_op(KIND_QUERY, 15, 15, 15, 0, 0));
		directed.push_back(make_op(KIND_QUERY, 16, 0, 0, 0, 0));        // outside
		directed.push_back(make_op(KIND_QUERY, 0, 255, 0, 0, 0));
		directed.push_back(make_op(KIND_QUERY, 0, 0, 128, 0, 0));
		directed.push_back(make_op(KIND_INSERT, 1, 0, 0, 5, 0));
		directed.push_back(make_op(KIND_QUERY, 1, 1, 1, 1, 0));
		directed.push_back(make_op(KIND_INSERT, 0, 0, 0, -1, 0));
		directed.push_back(make_op(KIND_INSERT, 1, 0, 0, -1, 0));
		directed.push_back(make_op(KIND_INSERT, 15, 15, 15, -1, 0));    // merges to root
		directed.push_back(make_op(KIND_QUERY, 15, 15, 15, 0, 0));
		directed.push_back(make_op(KIND_QUERY, 170, 85, 170, 0, 10));
		directed.push_back(make_op(KIND_INSERT, 85, 170, 85, 1, 5));
		directed.push_back(make_op(KIND_QUERY, 5, 10, 5, 3, 0));
		foreach (directed[i]) send_op(directed[i]);
		drain();   // sender holds off until every result is back

		// random phases over several tree sizes and stall patterns
		for (int p = 0; p < 6; p++) begin
			write_levels(phase_levels[p]);
			case (p / 2)
				0: begin send_idle_pct = 32; recv_stall_pct = 54; end
				1: begin send_idle_pct = 54; recv_stall_pct = 32; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int n = 0; n < 130; n++) begin
				// big tree: wide random inserts so the store fills up
				if (p == 0 && n < 90)
					send_op(make_op(KIND_INSERT, int'($urandom_range(255)),
						int'($urandom_range(255)), int'($urandom_range(255)),
						int'($urandom_range(32767)), 0));
				else
					send_op(random_op());
			end
			drain();
		end

		if (octree_sb.mismatches == 0 && octree_sb.replies_due.size() == 0)
			$display("sparse_voxel_octree_engine_test: done, clean");
		else
			$display("sparse_voxel_octree_engine_test: done, errors");
		$finish;
	end

endmodule

// ===== sparse_voxel_octree_engine.f =====
+incdir+hdl
hdl/svo_pkg.sv
hdl/svo_ram.sv
hdl/sparse_voxel_octree_engine.sv
hdl/svo_checker.sv
dv/sparse_voxel_octree_engine_test.sv
